FILE: hw/rtl/grid_line_traversal_4d_macros.svh
// Assertion helpers for the grid line traversal block
`ifndef GRID_LINE_TRAVERSAL_4D_MACROS_SVH
`define GRID_LINE_TRAVERSAL_4D_MACROS_SVH

// checked on clk, off while rst is high
`define GLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on clk at every edge, also during reset
`define GLT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/glt4d_pkg.sv
// ----------------------------------------------------------------------------
// glt4d_pkg
// Shared types and constants of the 4-D grid line traversal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glt4d_pkg;

  localparam int NAXIS = 4;
  localparam int NPAIR = 6;
  localparam int NPROD = 2 * NPAIR;

  // axis pairs (i < j) of the cross-product differences
  localparam logic [1:0] PAIR_I [NPAIR] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [NPAIR] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [3:0] mul_idx;
    logic       emit;
    logic       last;
    logic       trunc;
  } cmd_t;

  typedef struct packed {
    logic at_end;
  } status_t;

  function automatic logic [2:0] pair_of(logic [1:0] i, logic [1:0] j);
    logic [2:0] p;
    unique case ({i, j})
      4'b0001: p = 3'd0;
      4'b0010: p = 3'd1;
      4'b0011: p = 3'd2;
      4'b0110: p = 3'd3;
      4'b0111: p = 3'd4;
      4'b1011: p = 3'd5;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/glt4d_ctrl.sv
// ----------------------------------------------------------------------------
// glt4d_ctrl
// Sequencer: setup products, cell walk, output register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_line_traversal_4d_macros.svh"

module glt4d_ctrl #(
  parameter int MAX_CELLS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire glt4d_pkg::status_t status,
  output glt4d_pkg::cmd_t        cmd
);
  import glt4d_pkg::*;

  localparam int CW = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_CELLS - 1);

  state_t        state, state_next;
  logic [3:0]    k, k_next;
  logic [CW-1:0] count, count_next;
  logic          ob_valid, ob_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      count    <= '0;
      ob_valid <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      count    <= count_next;
      ob_valid <= ob_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    count_next    = count;
    ob_valid_next = ob_valid && !m_tready;
    cmd           = '0;
    s_tready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          k_next     = '0;
          count_next = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (k < 4'(NPROD)) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_idx = k;
        end
        k_next      = k + 4'd1;
        if (k == 4'(NPROD)) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!ob_valid || m_tready) begin
          cmd.emit      = 1'b1;
          cmd.last      = status.at_end || (count == CNT_LAST);
          cmd.trunc     = !status.at_end && (count == CNT_LAST);
          ob_valid_next = 1'b1;
          count_next    = count + 1'b1;
          if (cmd.last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign m_tvalid = ob_valid;

  `GLT_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state == ST_MUL), "accept did not start setup")
  `GLT_ASSERT(a_setup_len, (state == ST_MUL && k == 4'(NPROD)) |=> (state == ST_WALK), "setup overran")
  `GLT_ASSERT(a_last_ends, (cmd.emit && cmd.last) |=> (state == ST_IDLE && m_tvalid), "last result lost")
  `GLT_ASSERT_ALWAYS(a_no_ready_busy, (state != ST_IDLE) |-> !s_tready, "ready while busy")
endmodule

`default_nettype wire

FILE: hw/rtl/glt4d_dp.sv
// ----------------------------------------------------------------------------
// glt4d_dp
// Datapath: cell indices, exact crossing-time differences, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glt4d_dp #(
  parameter int MAX_CELLS = 64,
  parameter int FRAC_BITS = 14,
  parameter int INT_BITS  = 10,
  localparam int IN_BITS  = INT_BITS + FRAC_BITS,
  localparam int CB       = INT_BITS + 1,
  localparam int ITW      = ((8 * IN_BITS + 7) / 8) * 8,
  localparam int OTW      = ((4 * CB + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire glt4d_pkg::cmd_t    cmd,
  input  wire logic [ITW-1:0]     s_tdata,
  output glt4d_pkg::status_t      status,
  output logic [OTW-1:0]          m_tdata,
  output logic                    m_tuser,
  output logic                    m_tlast
);
  import glt4d_pkg::*;

  localparam int NUMW = FRAC_BITS + 1;
  localparam int PW   = NUMW + IN_BITS;
  localparam int DW   = FRAC_BITS + $clog2(MAX_CELLS + 2) + 2 + IN_BITS;

  logic signed [CB-1:0]   pos  [NAXIS];
  logic signed [CB-1:0]   endc [NAXIS];
  logic                   neg  [NAXIS];
  logic [IN_BITS-1:0]     mag  [NAXIS];
  logic [NUMW-1:0]        num0 [NAXIS];
  logic signed [DW-1:0]   diff [NPAIR];
  logic [PW-1:0]          prod;
  logic                   acc_en;
  logic [3:0]             acc_idx;
  logic signed [CB-1:0]   ob_cell [NAXIS];
  logic                   ob_last, ob_trunc;

  logic [1:0] best;
  logic       found;
  logic [2:0] mp;
  logic [1:0] ma, mb;

  always_comb begin
    found = 1'b0;
    best  = 2'd0;
    for (int c = 0; c < NAXIS; c++) begin
      if (pos[c] != endc[c]) begin
        if (!found) begin
          found = 1'b1;
          best  = 2'(c);
        end else if (diff[pair_of(best, 2'(c))] > 0) begin
          best = 2'(c);
        end
      end
    end
  end

  assign status.at_end = !found;

  assign mp = cmd.mul_idx[3:1];
  assign ma = cmd.mul_idx[0] ? PAIR_J[mp] : PAIR_I[mp];
  assign mb = cmd.mul_idx[0] ? PAIR_I[mp] : PAIR_J[mp];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en  <= 1'b0;
      acc_idx <= '0;
    end else begin
      acc_en  <= cmd.mul_en;
      acc_idx <= cmd.mul_idx;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [IN_BITS-1:0] s, r;
    logic signed [IN_BITS:0]   e;
    if (cmd.load) begin
      for (int c = 0; c < NAXIS; c++) begin
        s = s_tdata[c*IN_BITS +: IN_BITS];
        r = s_tdata[(NAXIS+c)*IN_BITS +: IN_BITS];
        e = {s[IN_BITS-1], s} + {r[IN_BITS-1], r};
        pos[c]  <= CB'(s >>> FRAC_BITS);
        endc[c] <= CB'(e >>> FRAC_BITS);
        neg[c]  <= r[IN_BITS-1];
        mag[c]  <= r[IN_BITS-1] ? (~r + 1'b1) : r;
        num0[c] <= r[IN_BITS-1] ? {1'b0, s[FRAC_BITS-1:0]}
                                : (NUMW'(1) << FRAC_BITS) - NUMW'(s[FRAC_BITS-1:0]);
      end
    end
    if (cmd.mul_en) prod <= num0[ma] * mag[mb];
    if (acc_en) begin
      if (!acc_idx[0]) diff[acc_idx[3:1]] <= DW'(prod);
      else diff[acc_idx[3:1]] <= diff[acc_idx[3:1]] - DW'(prod);
    end
    if (cmd.emit) begin
      for (int c = 0; c < NAXIS; c++) ob_cell[c] <= pos[c];
      ob_last  <= cmd.last;
      ob_trunc <= cmd.trunc;
      if (!cmd.last) begin
        pos[best] <= neg[best] ? pos[best] - 1'b1 : pos[best] + 1'b1;
        for (int p = 0; p < NPAIR; p++) begin
          if (PAIR_I[p] == best) diff[p] <= diff[p] + DW'({mag[PAIR_J[p]], {FRAC_BITS{1'b0}}});
          else if (PAIR_J[p] == best)
            diff[p] <= diff[p] - DW'({mag[PAIR_I[p]], {FRAC_BITS{1'b0}}});
        end
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int c = 0; c < NAXIS; c++) m_tdata[c*CB +: CB] = ob_cell[c];
  end
  assign m_tuser = ob_trunc;
  assign m_tlast = ob_last;
endmodule

`default_nettype wire

FILE: hw/rtl/grid_line_traversal_4d.sv
// ----------------------------------------------------------------------------
// grid_line_traversal_4d
// Walks a 4-D segment through the unit grid and streams every cell it visits.
// ----------------------------------------------------------------------------
// Slave channel: one request per segment, start point and offset, four signed
//   fixed-point components each (INT_BITS.FRAC_BITS).
// Master channel: one request per visited cell, from floor(start) to
//   floor(start + ray); tlast marks the final cell, tuser flags that the
//   MAX_CELLS limit cut the walk short.
// Setup: after the segment is accepted, 12 cross products run on one shared
//   multiplier and the last product is accumulated before the first cell.
// Throughput: one cell per cycle while the receiver accepts. Each step updates
//   the exact crossing-time differences of the three axis pairs that hold the
//   stepped axis.
// The next segment is accepted as soon as the final cell sits in the output
//   register. A stalled receiver holds the walk; nothing is dropped.
// Reset (rst, synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_line_traversal_4d #(
  parameter int MAX_CELLS = 64,
  parameter int FRAC_BITS = 14,
  parameter int INT_BITS  = 10,
  localparam int IN_BITS  = INT_BITS + FRAC_BITS,
  localparam int CB       = INT_BITS + 1,
  localparam int ITW      = ((8 * IN_BITS + 7) / 8) * 8,
  localparam int OTW      = ((4 * CB + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  // start_x, start_y, start_z, start_w, ray_x, ray_y, ray_z, ray_w
  input  wire logic [ITW-1:0] s_tdata,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  // cell_x, cell_y, cell_z, cell_w
  output logic [OTW-1:0]      m_tdata,
  // truncated
  output logic                m_tuser,
  output logic                m_tlast
);
  import glt4d_pkg::*;

  cmd_t    cmd;
  status_t status;

  glt4d_ctrl #(
    .MAX_CELLS(MAX_CELLS)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .status(status), .cmd(cmd)
  );

  glt4d_dp #(
    .MAX_CELLS(MAX_CELLS), .FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .s_tdata(s_tdata), .status(status),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );
endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_line_traversal_4d: random and directed 4-D
// segments go in on the slave stream, every visited cell is predicted in
// exact fixed point and compared on the master stream, under varied idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC     = 14;
  localparam int INW      = 24;
  localparam int CW       = 11;
  localparam int CELL_CAP = 64;
  localparam int ITW      = 192;
  localparam int OTW      = 48;
  localparam int N_RANDOM = 250;
  localparam int DRAIN_AT = 20;
  localparam int WDOG_MAX = 20000;
  localparam longint ONE  = 64'sd1 << FRAC;

  typedef struct {
    logic signed [INW-1:0] start [4];
    logic signed [INW-1:0] ray [4];
  } segment_t;

  typedef struct {
    logic [CW-1:0] idx [4];
    logic          last;
    logic          trunc;
  } cell_rec_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [ITW-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [OTW-1:0] m_tdata;
  logic           m_tuser;
  logic           m_tlast;

  segment_t  pending_segs [$];
  cell_rec_t expected_cells [$];
  int        segs_sent = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  bit        took = 1'b0;

  grid_line_traversal_4d i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  function automatic longint frac_of(longint v);
    return v & (ONE - 1);
  endfunction

  function automatic longint floor_of(longint v);
    return (v - frac_of(v)) / ONE;
  endfunction

  // exact walk: crossing times compared by cross multiplication
  function automatic void walk_cells(segment_t sg);
    longint cur [4], stop [4], mag [4], gap [4], step [4];
    int count, best;
    bit done;
    cell_rec_t r;
    count = 0;
    for (int c = 0; c < 4; c++) begin
      longint s, d;
      s = longint'(sg.start[c]);
      d = longint'(sg.ray[c]);
      cur[c] = floor_of(s);
      stop[c] = floor_of(s + d);
      if (d < 0) begin
        step[c] = -1; mag[c] = -d; gap[c] = frac_of(s);
      end else begin
        step[c] = 1; mag[c] = d; gap[c] = ONE - frac_of(s);
      end
    end
    forever begin
      done = 1'b1;
      for (int c = 0; c < 4; c++) begin
        if (cur[c] != stop[c]) done = 1'b0;
        r.idx[c] = cur[c][CW-1:0];
      end
      r.last = 1'b0;
      r.trunc = 1'b0;
      count++;
      if (done) begin
        r.last = 1'b1;
        expected_cells.push_back(r);
        break;
      end
      if (count >= CELL_CAP) begin
        r.last = 1'b1;
        r.trunc = 1'b1;
        expected_cells.push_back(r);
        break;
      end
      expected_cells.push_back(r);
      best = -1;
      for (int c = 0; c < 4; c++) begin
        if (cur[c] == stop[c]) continue;
        if (best < 0 || gap[c] * mag[best] < gap[best] * mag[c]) best = c;
      end
      cur[best] += step[best];
      gap[best] += ONE;
    end
  endfunction

  function automatic int phase_of(int n);
    return (n / 64) % 4;
  endfunction

  // driver
  always @(negedge clk) begin
    int ph;
    bit idle;
    segment_t sg;
    logic [ITW-1:0] d;
    ph = phase_of(segs_sent);
    if (!rst) begin
      case (ph)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'b1;
        2: m_tready <= ($urandom_range(99) >= 72);
        default: m_tready <= ($urandom_range(99) >= 18);
      endcase
      if (!s_tvalid || took) begin
        took = 1'b0;
        case (ph)
          1: idle = ($urandom_range(99) < 72);
          3: idle = ($urandom_range(99) < 18);
          default: idle = 1'b0;
        endcase
        if (segs_sent == DRAIN_AT && expected_cells.size() != 0) idle = 1'b1;
        if (!idle && pending_segs.size() != 0) begin
          sg = pending_segs.pop_front();
          d = '0;
          for (int c = 0; c < 4; c++) begin
            d[INW*c +: INW] = sg.start[c];
            d[INW*(c+4) +: INW] = sg.ray[c];
          end
          s_tdata <= d;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    segment_t sg;
    cell_rec_t e;
    bit moved;
    moved = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      for (int c = 0; c < 4; c++) begin
        sg.start[c] = s_tdata[INW*c +: INW];
        sg.ray[c] = s_tdata[INW*(c+4) +: INW];
      end
      walk_cells(sg);
      segs_sent++;
      took = 1'b1;
      moved = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      moved = 1'b1;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell %h last %b trunc %b", $time, m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        for (int c = 0; c < 4; c++)
          if (m_tdata[CW*c +: CW] !== e.idx[c]) begin
            $display("%0t: cell axis %0d expected %0d got %0d", $time, c,
                     $signed(e.idx[c]), $signed(m_tdata[CW*c +: CW]));
            errors++;
          end
        if (m_tlast !== e.last) begin
          $display("%0t: tlast expected %b got %b", $time, e.last, m_tlast);
          errors++;
        end
        if (m_tuser !== e.trunc) begin
          $display("%0t: truncated expected %b got %b", $time, e.trunc, m_tuser);
          errors++;
        end
      end
    end
    if (moved || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [INW-1:0] rand_coord(int span_units);
    int lim;
    lim = span_units << FRAC;
    return INW'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  task automatic add_seg(longint sx, longint sy, longint sz, longint sw,
                         longint rx, longint ry, longint rz, longint rw);
    segment_t sg;
    sg.start[0] = INW'(sx); sg.start[1] = INW'(sy);
    sg.start[2] = INW'(sz); sg.start[3] = INW'(sw);
    sg.ray[0] = INW'(rx); sg.ray[1] = INW'(ry);
    sg.ray[2] = INW'(rz); sg.ray[3] = INW'(rw);
    pending_segs.push_back(sg);
  endtask

  initial begin
    segment_t sg;
    int pick;
    // directed: zero ray, ties, integer starts going negative, extremes
    add_seg(0, 0, 0, 0, 0, 0, 0, 0);
    add_seg(8192, 8192, 8192, 8192, 32768, 32768, 32768, 32768);
    add_seg(0, 0, 0, 0, -16384, -16384, -16384, -16384);
    add_seg(16384, -32768, 0, 49152, -40000, 20000, 0, -5);
    add_seg(100, 200, 300, 400, 50000, 0, 0, 0);
    add_seg(100, 200, 300, 400, 0, -50000, 0, 0);
    add_seg(100, 200, 300, 400, 0, 0, 50000, 0);
    add_seg(100, 200, 300, 400, 0, 0, 0, -50000);
    add_seg(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    add_seg(-8388608, -8388608, -8388608, -8388608,
            -8388608, -8388608, -8388608, -8388608);
    add_seg(8388607, -8388608, 8388607, -8388608, -8388608, 8388607, 1, -1);
    add_seg(0, 0, 0, 0, 16383, 1, -1, -16384);
    add_seg(5000, 5000, 5000, 5000, 3000000, -3000000, 3000000, -3000000);
    add_seg(16383, -1, 1, -16383, 1, -1, 16384, -16384);
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      for (int c = 0; c < 4; c++) begin
        if (pick < 15) begin
          sg.start[c] = INW'($urandom);
          sg.ray[c] = INW'($urandom);
        end else begin
          sg.start[c] = ($urandom_range(9) == 0) ? INW'($signed($urandom_range(40)) - 20) << FRAC
                                                 : rand_coord(300);
          sg.ray[c] = ($urandom_range(5) == 0) ? '0 : rand_coord(pick < 85 ? 4 : 30);
        end
      end
      pending_segs.push_back(sg);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_segs.size() == 0 && !s_tvalid);
    wait (expected_cells.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_cells.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
